// ----- design/u51bt_pkg.sv -----
// ----------------------------------------------------------------------------
// u51bt_pkg
// Shared types, codes and constants for the 8051 serial port timing model.
// ----------------------------------------------------------------------------
package u51bt_pkg;

  // accumulator width for clock and timer-overflow counts
  localparam int ACC_WIDTH = 16;

  // divide by 12 is done as (acc >> 2) / 3 with a reciprocal multiply
  localparam int Q3_W     = ACC_WIDTH - 2;
  localparam int Q3_SHIFT = Q3_W + 1;
  localparam longint unsigned Q3_MUL_FULL = ((64'd1 << Q3_SHIFT) + 64'd2) / 64'd3;
  localparam logic [Q3_W-1:0] Q3_MUL = Q3_MUL_FULL[Q3_W-1:0];

  localparam logic [ACC_WIDTH-1:0] ACC_MAX  = {ACC_WIDTH{1'b1}};
  localparam logic [5:0]           BITS_MAX = 6'd63;

  // bit-time divisors
  localparam logic [5:0] DIV_12 = 6'd12;
  localparam logic [5:0] DIV_16 = 6'd16;
  localparam logic [5:0] DIV_32 = 6'd32;

  // frame lengths
  localparam logic [3:0] FRAME_8  = 4'd8;
  localparam logic [3:0] FRAME_10 = 4'd10;
  localparam logic [3:0] FRAME_11 = 4'd11;

  // serial modes
  localparam logic [1:0] MODE_0 = 2'd0;
  localparam logic [1:0] MODE_1 = 2'd1;

  // SCON / PCON / T2CON bit positions
  localparam int SCON_RI_BIT  = 0;
  localparam int SCON_TI_BIT  = 1;
  localparam int SCON_REN_BIT = 4;
  localparam int PCON_SMOD_BIT = 7;
  localparam logic [7:0] T2_CLK_MASK = 8'h30;

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_WRITE     = 3'd1,
    KIND_READ      = 3'd2,
    KIND_T1_OVF    = 3'd3,
    KIND_T2_OVF    = 3'd4,
    KIND_T2_MODE   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    SEL_SBUF     = 2'd0,
    SEL_SCON     = 2'd1,
    SEL_PCON     = 2'd2,
    SEL_SCON_BIT = 2'd3
  } reg_sel_t;

  // config register index
  localparam logic CFG_CLOCKS_PER_CYCLE = 1'b0;

  typedef struct packed {
    logic [7:0] rdata;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       ti_flag;
    logic       ri_flag;
  } result_t;

  function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                   input logic [ACC_WIDTH-1:0] b);
    logic [ACC_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_WIDTH] ? ACC_MAX : s[ACC_WIDTH-1:0];
  endfunction

endpackage

// ----- design/u51bt_bit_conv.sv -----
// ----------------------------------------------------------------------------
// u51bt_bit_conv
// Turns an accumulated count into whole bit times: adds acc / divisor to a
// saturating bit counter and leaves acc % divisor. Divisor is 12, 16 or 32.
// ----------------------------------------------------------------------------
module u51bt_bit_conv (
  input  logic [u51bt_pkg::ACC_WIDTH-1:0] acc,
  input  logic [5:0]                      bits,
  input  logic [5:0]                      divisor,
  output logic [u51bt_pkg::ACC_WIDTH-1:0] acc_rem,
  output logic [5:0]                      bits_sum
);
  import u51bt_pkg::*;

  logic [Q3_W-1:0]      quarter;
  logic [2*Q3_W-1:0]    prod;
  logic [ACC_WIDTH-1:0] q12;
  logic [ACC_WIDTH-1:0] quot;
  logic [ACC_WIDTH:0]   sum;

  assign quarter = acc[ACC_WIDTH-1:2];
  assign prod    = {{Q3_W{1'b0}}, quarter} * {{Q3_W{1'b0}}, Q3_MUL};
  assign q12     = ACC_WIDTH'(prod >> Q3_SHIFT);

  always_comb begin
    unique case (divisor)
      DIV_16: begin
        quot    = acc >> 4;
        acc_rem = {{(ACC_WIDTH-4){1'b0}}, acc[3:0]};
      end
      DIV_32: begin
        quot    = acc >> 5;
        acc_rem = {{(ACC_WIDTH-5){1'b0}}, acc[4:0]};
      end
      default: begin
        quot    = q12;
        acc_rem = acc - (q12 << 3) - (q12 << 2);
      end
    endcase
  end

  assign sum      = (ACC_WIDTH+1)'(bits) + {1'b0, quot};
  assign bits_sum = (sum > (ACC_WIDTH+1)'(BITS_MAX)) ? BITS_MAX : sum[5:0];

endmodule

// ----- design/uart_8051_bit_timing_model.sv -----
// ----------------------------------------------------------------------------
// uart_8051_bit_timing_model
// Event-level timing model of an 8051 serial port (SCON, PCON, SBUF, timer
// baud sources, bit and clock accumulators).
// ----------------------------------------------------------------------------
// Each input transfer is one event (tick, register write or read, timer
// overflow, timer-2 mode change) and yields exactly one result transfer. The
// whole update of the port state, including the bit-time conversion of both
// accumulators, is done in the cycle the event is taken, so a new event can
// be taken every clock while the skid register is free, and each result is
// registered. A two-entry result buffer (result register plus skid
// register) lets the input keep flowing while a result waits; the input
// stalls only while that skid register is occupied. clocks_per_cycle is set
// through the APB port at byte address 0 and reads back there.
module uart_8051_bit_timing_model (
  input  logic        clk,
  input  logic        rst,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [1:0]  reg_sel,
  input  logic [2:0]  bit_index,
  input  logic [7:0]  wdata,
  input  logic [3:0]  cycles,
  input  logic        rx_ready,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  rdata,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        ti_flag,
  output logic        ri_flag,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import u51bt_pkg::*;

  // configuration
  logic [3:0] clocks_per_cycle;

  // port state
  logic [7:0]           scon_reg,     scon_reg_next;
  logic [7:0]           pcon_byte,    pcon_byte_next;
  logic [7:0]           rx_buffer,    rx_buffer_next;
  logic [7:0]           tx_buffer,    tx_buffer_next;
  logic                 sending,      sending_next;
  logic                 receiving,    receiving_next;
  logic [5:0]           tx_bits_done, tx_bits_done_next;
  logic [5:0]           rx_bits_done, rx_bits_done_next;
  logic [ACC_WIDTH-1:0] tx_clock_acc, tx_clock_acc_next;
  logic [ACC_WIDTH-1:0] rx_clock_acc, rx_clock_acc_next;
  logic [ACC_WIDTH-1:0] tx_timer_acc, tx_timer_acc_next;
  logic [ACC_WIDTH-1:0] rx_timer_acc, rx_timer_acc_next;
  logic [3:0]           frame_bits,   frame_bits_next;
  logic [5:0]           divisor,      divisor_next;
  logic                 timer2_baud,  timer2_baud_next;

  // result buffer
  result_t res;
  result_t main_res, skid_res;
  logic    main_valid, skid_valid;

  logic accept;
  logic out_take;

  // tick datapath
  logic                 timed;
  logic [5:0]           div_eff;
  logic [ACC_WIDTH-1:0] tx_src_acc, rx_src_acc;
  logic [ACC_WIDTH-1:0] tx_rem, rx_rem;
  logic [5:0]           tx_conv_bits, rx_conv_bits;
  logic [ACC_WIDTH-1:0] clk_add;
  logic                 smod_now;
  kind_t                kind_c;
  reg_sel_t             sel_c;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_take = main_valid && !out_stall;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_CLOCKS_PER_CYCLE) ? {28'd0, clocks_per_cycle} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clocks_per_cycle <= 4'd1;
    end else if (psel && penable && pwrite && pready && paddr[2] == CFG_CLOCKS_PER_CYCLE) begin
      clocks_per_cycle <= pwdata[3:0];
    end
  end

  // ---------------------------------------------------------------------------
  // bit-time conversion, one unit per direction
  // ---------------------------------------------------------------------------
  assign timed      = scon_reg[6];          // modes 1 and 3 count timer overflows
  assign div_eff    = timer2_baud ? DIV_16 : divisor;
  assign tx_src_acc = timed ? tx_timer_acc : tx_clock_acc;
  assign rx_src_acc = timed ? rx_timer_acc : rx_clock_acc;
  assign clk_add    = ACC_WIDTH'(cycles * clocks_per_cycle);

  u51bt_bit_conv u_tx_conv (
    .acc      (tx_src_acc),
    .bits     (tx_bits_done),
    .divisor  (div_eff),
    .acc_rem  (tx_rem),
    .bits_sum (tx_conv_bits)
  );

  u51bt_bit_conv u_rx_conv (
    .acc      (rx_src_acc),
    .bits     (rx_bits_done),
    .divisor  (div_eff),
    .acc_rem  (rx_rem),
    .bits_sum (rx_conv_bits)
  );

  // ---------------------------------------------------------------------------
  // event update
  // ---------------------------------------------------------------------------
  assign kind_c   = kind_t'(kind);
  assign sel_c    = reg_sel_t'(reg_sel);
  assign smod_now = pcon_byte[PCON_SMOD_BIT];

  always_comb begin
    scon_reg_next     = scon_reg;
    pcon_byte_next    = pcon_byte;
    rx_buffer_next    = rx_buffer;
    tx_buffer_next    = tx_buffer;
    sending_next      = sending;
    receiving_next    = receiving;
    tx_bits_done_next = tx_bits_done;
    rx_bits_done_next = rx_bits_done;
    tx_clock_acc_next = tx_clock_acc;
    rx_clock_acc_next = rx_clock_acc;
    tx_timer_acc_next = tx_timer_acc;
    rx_timer_acc_next = rx_timer_acc;
    frame_bits_next   = frame_bits;
    divisor_next      = divisor;
    timer2_baud_next  = timer2_baud;
    res               = '0;

    unique case (kind_c)
      KIND_TICK: begin
        divisor_next = div_eff;
        if (sending) begin
          tx_bits_done_next = tx_conv_bits;
          if (timed) tx_timer_acc_next = tx_rem;
          else       tx_clock_acc_next = tx_rem;
        end
        if (receiving) begin
          rx_bits_done_next = rx_conv_bits;
          if (timed) rx_timer_acc_next = rx_rem;
          else       rx_clock_acc_next = rx_rem;
        end
        if (sending && tx_bits_done_next >= {2'b00, frame_bits}) begin
          sending_next                = 1'b0;
          scon_reg_next[SCON_TI_BIT]  = 1'b1;
          res.tx_valid                = 1'b1;
          res.tx_byte                 = tx_buffer;
          tx_bits_done_next           = tx_bits_done_next - {2'b00, frame_bits};
        end
        // start of reception
        if (scon_reg[SCON_REN_BIT] && !receiving && rx_ready) begin
          receiving_next    = 1'b1;
          rx_bits_done_next = '0;
          rx_clock_acc_next = '0;
          rx_timer_acc_next = '0;
        end
        if (receiving_next && rx_bits_done_next >= {2'b00, frame_bits}) begin
          if (rx_ready) begin
            rx_buffer_next             = rx_byte;
            scon_reg_next[SCON_RI_BIT] = 1'b1;
          end
          receiving_next    = 1'b0;
          rx_bits_done_next = rx_bits_done_next - {2'b00, frame_bits};
        end
        tx_clock_acc_next = sat_add(tx_clock_acc_next, clk_add);
        rx_clock_acc_next = sat_add(rx_clock_acc_next, clk_add);
      end
      KIND_WRITE: begin
        unique case (sel_c)
          SEL_SBUF: begin
            tx_buffer_next    = wdata;
            sending_next      = 1'b1;
            tx_bits_done_next = '0;
            tx_clock_acc_next = '0;
            tx_timer_acc_next = '0;
          end
          SEL_PCON: begin
            pcon_byte_next = wdata;
            if (scon_reg[7:6] != MODE_0)
              divisor_next = wdata[PCON_SMOD_BIT] ? DIV_16 : DIV_32;
          end
          SEL_SCON, SEL_SCON_BIT: begin
            if (sel_c == SEL_SCON) scon_reg_next = wdata;
            else                   scon_reg_next[bit_index] = (wdata != 8'd0);
            if (scon_reg_next[7:6] == MODE_0) begin
              frame_bits_next = FRAME_8;
              divisor_next    = DIV_12;
            end else begin
              frame_bits_next = (scon_reg_next[7:6] == MODE_1) ? FRAME_10 : FRAME_11;
              divisor_next    = smod_now ? DIV_16 : DIV_32;
            end
          end
          default: ;
        endcase
      end
      KIND_READ: begin
        unique case (sel_c)
          SEL_SBUF: res.rdata = rx_buffer;
          SEL_SCON: res.rdata = scon_reg;
          SEL_PCON: res.rdata = pcon_byte;
          default:  res.rdata = {7'd0, scon_reg[bit_index]};
        endcase
      end
      KIND_T1_OVF, KIND_T2_OVF: begin
        tx_timer_acc_next = sat_add(tx_timer_acc, ACC_WIDTH'(1));
        rx_timer_acc_next = sat_add(rx_timer_acc, ACC_WIDTH'(1));
      end
      KIND_T2_MODE: begin
        if (!timer2_baud) begin
          tx_timer_acc_next = '0;
          rx_timer_acc_next = '0;
        end
        timer2_baud_next = (wdata & T2_CLK_MASK) != 8'd0;
      end
      default: ;
    endcase

    res.ti_flag = scon_reg_next[SCON_TI_BIT];
    res.ri_flag = scon_reg_next[SCON_RI_BIT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scon_reg     <= '0;
      pcon_byte    <= '0;
      rx_buffer    <= '0;
      tx_buffer    <= '0;
      sending      <= 1'b0;
      receiving    <= 1'b0;
      tx_bits_done <= '0;
      rx_bits_done <= '0;
      tx_clock_acc <= '0;
      rx_clock_acc <= '0;
      tx_timer_acc <= '0;
      rx_timer_acc <= '0;
      frame_bits   <= FRAME_8;
      divisor      <= DIV_12;
      timer2_baud  <= 1'b0;
    end else if (accept) begin
      scon_reg     <= scon_reg_next;
      pcon_byte    <= pcon_byte_next;
      rx_buffer    <= rx_buffer_next;
      tx_buffer    <= tx_buffer_next;
      sending      <= sending_next;
      receiving    <= receiving_next;
      tx_bits_done <= tx_bits_done_next;
      rx_bits_done <= rx_bits_done_next;
      tx_clock_acc <= tx_clock_acc_next;
      rx_clock_acc <= rx_clock_acc_next;
      tx_timer_acc <= tx_timer_acc_next;
      rx_timer_acc <= rx_timer_acc_next;
      frame_bits   <= frame_bits_next;
      divisor      <= divisor_next;
      timer2_baud  <= timer2_baud_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register with skid entry
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_take) begin
      main_valid <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_take) begin
      main_res <= skid_valid ? skid_res : res;
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign out_valid = main_valid;
  assign rdata     = main_res.rdata;
  assign tx_valid  = main_res.tx_valid;
  assign tx_byte   = main_res.tx_byte;
  assign ti_flag   = main_res.ti_flag;
  assign ri_flag   = main_res.ri_flag;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry occupied while result register empty");

  a_divisor_legal: assert property (@(posedge clk) disable iff (rst)
    divisor == DIV_12 || divisor == DIV_16 || divisor == DIV_32)
    else $error("divisor left the set 12, 16, 32");

  a_tx_done_stops: assert property (@(posedge clk) disable iff (rst)
    accept && res.tx_valid |=> !sending && scon_reg[SCON_TI_BIT])
    else $error("completed transfer did not clear sending or set TI");

  a_tx_sets_ti: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid |-> ti_flag)
    else $error("transmitted byte reported without TI");

endmodule
